### rtl/smt_pkg.sv
// Package: shared types, codes and defaults for the sorted membership table.
`timescale 1ns / 1ps
package smt_pkg;

	localparam int IN_DEPTH_DEF    = 64;
	localparam int OUT_DEPTH_DEF   = 64;
	localparam int INDEX_WIDTH_DEF = 16;
	localparam int FIELD_W         = 16;
	localparam int COUNT_W         = 7;

	localparam logic [1:0] ACT_ADD_IN  = 2'd0;
	localparam logic [1:0] ACT_ADD_OUT = 2'd1;
	localparam logic [1:0] ACT_QUERY   = 2'd2;
	localparam logic [1:0] ACT_SQUARE  = 2'd3;

	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_SAME     = 3'd1;
	localparam logic [2:0] STAT_CONTRA   = 3'd2;
	localparam logic [2:0] STAT_CONFLICT = 3'd3;
	localparam logic [2:0] STAT_FULL     = 3'd4;
	localparam logic [2:0] STAT_SQDONE   = 3'd5;

	localparam logic [1:0] MEM_UNSURE = 2'd0;
	localparam logic [1:0] MEM_IN     = 2'd1;
	localparam logic [1:0] MEM_OUT    = 2'd2;

	typedef enum logic [1:0] {
		OP_ADD_IN,
		OP_ADD_OUT,
		OP_QUERY,
		OP_SQUARE
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT,
		S_SHIFT_END,
		S_PLACE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [FIELD_W-1:0] index;
		logic [FIELD_W-1:0] preimage;
		logic               preimage_given;
	} smt_in_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [1:0]         membership;
		logic [FIELD_W-1:0] found_preimage;
		logic               preimage_known;
		logic [COUNT_W-1:0] in_count;
		logic [COUNT_W-1:0] out_count;
		logic               changed;
	} smt_out_t;

	typedef struct packed {
		op_t                op;
		logic [FIELD_W-1:0] index;
		logic [FIELD_W-1:0] preimage;
		logic               given;
	} smt_cmd_t;

endpackage

### rtl/smt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module smt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/smt_front.sv
// Front stage: accept input transactions, mask fields and decode the action.
`timescale 1ns / 1ps
module smt_front #(
	parameter int INDEX_WIDTH = smt_pkg::INDEX_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  smt_pkg::smt_in_t   in_data,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output smt_pkg::smt_cmd_t  cmd
);

	localparam int VW = (INDEX_WIDTH < smt_pkg::FIELD_W) ? INDEX_WIDTH : smt_pkg::FIELD_W;
	localparam logic [smt_pkg::FIELD_W-1:0] MASK =
		smt_pkg::FIELD_W'((64'd1 << VW) - 64'd1);

	smt_pkg::smt_cmd_t cmd_s1;
	smt_pkg::smt_cmd_t cmd_d;
	logic              vld_s1;

	always_comb begin
		case (in_data.action)
			smt_pkg::ACT_ADD_IN:  cmd_d.op = smt_pkg::OP_ADD_IN;
			smt_pkg::ACT_ADD_OUT: cmd_d.op = smt_pkg::OP_ADD_OUT;
			smt_pkg::ACT_QUERY:   cmd_d.op = smt_pkg::OP_QUERY;
			default:              cmd_d.op = smt_pkg::OP_SQUARE;
		endcase
		cmd_d.index    = in_data.index & MASK;
		cmd_d.preimage = in_data.preimage & MASK;
		cmd_d.given    = in_data.preimage_given;
	end

	assign in_ready  = !vld_s1 || cmd_ready;
	assign cmd_valid = vld_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

### rtl/smt_fifo.sv
// Two-entry command queue between the front and back parts.
`timescale 1ns / 1ps
module smt_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] ent_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = ent_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### rtl/smt_back.sv
// Back part: scan both sorted sets, decide, shift and place entries, build results.
`timescale 1ns / 1ps
module smt_back #(
	parameter int IN_DEPTH    = smt_pkg::IN_DEPTH_DEF,
	parameter int OUT_DEPTH   = smt_pkg::OUT_DEPTH_DEF,
	parameter int INDEX_WIDTH = smt_pkg::INDEX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  smt_pkg::smt_cmd_t           cmd,
	input  logic                        cfg_we,
	input  logic [smt_pkg::FIELD_W-1:0] cfg_wdata,
	output logic                        out_valid,
	input  logic                        out_ready,
	output smt_pkg::smt_out_t           out_data
);

	localparam int VW   = (INDEX_WIDTH < smt_pkg::FIELD_W) ? INDEX_WIDTH : smt_pkg::FIELD_W;
	localparam int IAW  = $clog2(IN_DEPTH);
	localparam int OAW  = $clog2(OUT_DEPTH);
	localparam int ICW  = $clog2(IN_DEPTH + 1);
	localparam int OCW  = $clog2(OUT_DEPTH + 1);
	localparam int MAXD = (IN_DEPTH > OUT_DEPTH) ? IN_DEPTH : OUT_DEPTH;
	localparam int SW   = $clog2(MAXD + 1);
	localparam int EW   = 2 * VW + 1;

	smt_pkg::state_t state_q, state_d;

	logic [VW-1:0]  own_q;
	smt_pkg::op_t   op_q;
	logic [VW-1:0]  v_q;
	logic [VW-1:0]  pre_q;
	logic           given_q;
	logic [ICW-1:0] in_fill_q;
	logic [OCW-1:0] out_fill_q;
	logic           sq_set_q;
	logic           changed_q;

	logic [SW-1:0]  scan_idx_q;
	logic           scan_vld_s1;
	logic [SW-1:0]  scan_idx_s1;
	logic [SW-1:0]  scan_len;
	logic           scan_issue;

	logic           in_found_q;
	logic [IAW-1:0] in_pos_q;
	logic [ICW-1:0] in_at_q;
	logic [VW-1:0]  in_pre_q;
	logic           in_pv_q;
	logic           out_found_q;
	logic [OCW-1:0] out_at_q;

	logic [2:0]     res_status_q;
	logic [1:0]     res_member_q;
	logic [VW-1:0]  res_fpre_q;
	logic           res_known_q;

	logic           tgt_out_q;
	logic           ins_q;
	logic [SW-1:0]  place_addr_q;
	logic [EW-1:0]  place_data_q;
	logic [SW-1:0]  sh_q;
	logic [SW-1:0]  sh_stop_q;
	logic           pend_s1;
	logic [SW-1:0]  pend_addr_s1;

	smt_pkg::smt_out_t out_q;
	logic              out_valid_q;

	// decision
	logic [2:0]     d_status;
	logic [1:0]     d_member;
	logic [VW-1:0]  d_fpre;
	logic           d_known;
	logic           d_upd;
	logic           d_ins_in;
	logic           d_ins_out;
	logic           d_sq_first;
	logic [VW-1:0]  d_pre;
	logic           d_given;
	logic           d_add_in;
	logic           d_shift;

	// RAM ports
	logic           in_we;
	logic [IAW-1:0] in_waddr;
	logic [EW-1:0]  in_wdata;
	logic [IAW-1:0] in_raddr;
	logic [EW-1:0]  in_rdata;
	logic           out_we;
	logic [OAW-1:0] out_waddr;
	logic [VW-1:0]  out_wdata;
	logic [OAW-1:0] out_raddr;
	logic [VW-1:0]  out_rdata;
	logic [VW-1:0]  in_rval;

	smt_ram #(.WIDTH(EW), .DEPTH(IN_DEPTH)) u_in_ram (
		.clk   (clk),
		.we    (in_we),
		.waddr (in_waddr),
		.wdata (in_wdata),
		.raddr (in_raddr),
		.rdata (in_rdata)
	);

	smt_ram #(.WIDTH(VW), .DEPTH(OUT_DEPTH)) u_out_ram (
		.clk   (clk),
		.we    (out_we),
		.waddr (out_waddr),
		.wdata (out_wdata),
		.raddr (out_raddr),
		.rdata (out_rdata)
	);

	assign in_rval    = in_rdata[EW-1:VW+1];
	assign scan_len   = (SW'(in_fill_q) > SW'(out_fill_q)) ? SW'(in_fill_q) : SW'(out_fill_q);
	assign scan_issue = (state_q == smt_pkg::S_SCAN) && (scan_idx_q < scan_len);
	assign cmd_ready  = (state_q == smt_pkg::S_IDLE);
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	always_comb begin
		d_status   = smt_pkg::STAT_OK;
		d_upd      = 1'b0;
		d_ins_in   = 1'b0;
		d_ins_out  = 1'b0;
		d_sq_first = (op_q == smt_pkg::OP_SQUARE) && !sq_set_q;
		d_add_in   = (op_q == smt_pkg::OP_ADD_IN) || d_sq_first;
		d_pre      = d_sq_first ? own_q : pre_q;
		d_given    = d_sq_first || given_q;
		// default report: what the scan found
		if (in_found_q) begin
			d_member = smt_pkg::MEM_IN;
			d_known  = in_pv_q;
			d_fpre   = in_pv_q ? in_pre_q : '0;
		end else if (out_found_q) begin
			d_member = smt_pkg::MEM_OUT;
			d_known  = 1'b0;
			d_fpre   = '0;
		end else begin
			d_member = smt_pkg::MEM_UNSURE;
			d_known  = 1'b0;
			d_fpre   = '0;
		end
		if (op_q == smt_pkg::OP_SQUARE && sq_set_q) begin
			d_status = smt_pkg::STAT_SQDONE;
		end else if (d_add_in) begin
			if (in_found_q) begin
				if (!d_given) begin
					d_status = smt_pkg::STAT_SAME;
				end else if (in_pv_q) begin
					d_status = (in_pre_q == d_pre) ? smt_pkg::STAT_SAME : smt_pkg::STAT_CONFLICT;
				end else begin
					d_upd   = 1'b1;
					d_known = 1'b1;
					d_fpre  = d_pre;
				end
			end else if (out_found_q) begin
				d_status = smt_pkg::STAT_CONTRA;
			end else if (in_fill_q == ICW'(IN_DEPTH)) begin
				d_status = smt_pkg::STAT_FULL;
			end else begin
				d_ins_in = 1'b1;
				d_member = smt_pkg::MEM_IN;
				d_known  = d_given;
				d_fpre   = d_given ? d_pre : '0;
			end
		end else if (op_q == smt_pkg::OP_ADD_OUT) begin
			if (in_found_q || out_found_q) begin
				d_status = smt_pkg::STAT_SAME;
			end else if (out_fill_q == OCW'(OUT_DEPTH)) begin
				d_status = smt_pkg::STAT_FULL;
			end else begin
				d_ins_out = 1'b1;
				d_member  = smt_pkg::MEM_OUT;
			end
		end
		d_shift = (d_ins_in && (in_at_q < in_fill_q)) || (d_ins_out && (out_at_q < out_fill_q));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			smt_pkg::S_IDLE: begin
				if (cmd_valid) begin
					state_d = smt_pkg::S_SCAN;
				end
			end
			smt_pkg::S_SCAN: begin
				if (!scan_issue && !scan_vld_s1) begin
					state_d = smt_pkg::S_DECIDE;
				end
			end
			smt_pkg::S_DECIDE: begin
				if (d_shift) begin
					state_d = smt_pkg::S_SHIFT;
				end else if (d_upd || d_ins_in || d_ins_out) begin
					state_d = smt_pkg::S_PLACE;
				end else begin
					state_d = smt_pkg::S_DONE;
				end
			end
			smt_pkg::S_SHIFT: begin
				if (sh_q == sh_stop_q) begin
					state_d = smt_pkg::S_SHIFT_END;
				end
			end
			smt_pkg::S_SHIFT_END: state_d = smt_pkg::S_PLACE;
			smt_pkg::S_PLACE:     state_d = smt_pkg::S_DONE;
			smt_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = smt_pkg::S_IDLE;
				end
			end
			default: state_d = smt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_raddr  = (state_q == smt_pkg::S_SCAN) ? scan_idx_q[IAW-1:0] : sh_q[IAW-1:0];
		out_raddr = (state_q == smt_pkg::S_SCAN) ? scan_idx_q[OAW-1:0] : sh_q[OAW-1:0];
		in_we     = 1'b0;
		in_waddr  = pend_addr_s1[IAW-1:0];
		in_wdata  = in_rdata;
		out_we    = 1'b0;
		out_waddr = pend_addr_s1[OAW-1:0];
		out_wdata = out_rdata;
		case (state_q)
			smt_pkg::S_SHIFT, smt_pkg::S_SHIFT_END: begin
				in_we  = pend_s1 && !tgt_out_q;
				out_we = pend_s1 && tgt_out_q;
			end
			smt_pkg::S_PLACE: begin
				in_we     = !tgt_out_q;
				out_we    = tgt_out_q;
				in_waddr  = place_addr_q[IAW-1:0];
				out_waddr = place_addr_q[OAW-1:0];
				in_wdata  = place_data_q;
				out_wdata = v_q;
			end
			default: begin
				in_we  = 1'b0;
				out_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= smt_pkg::S_IDLE;
			own_q       <= '0;
			in_fill_q   <= '0;
			out_fill_q  <= '0;
			sq_set_q    <= 1'b0;
			changed_q   <= 1'b1;
			scan_vld_s1 <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				own_q <= cfg_wdata[VW-1:0];
			end
			scan_vld_s1 <= scan_issue;
			if (state_q == smt_pkg::S_DECIDE) begin
				if (d_sq_first) begin
					sq_set_q  <= 1'b1;
					changed_q <= 1'b1;
				end
				if (d_upd || d_ins_in || d_ins_out) begin
					changed_q <= 1'b1;
				end
			end
			if (state_q == smt_pkg::S_SHIFT) begin
				pend_s1 <= 1'b1;
			end else begin
				pend_s1 <= 1'b0;
			end
			if (state_q == smt_pkg::S_PLACE && ins_q) begin
				if (tgt_out_q) begin
					out_fill_q <= out_fill_q + OCW'(1);
				end else begin
					in_fill_q <= in_fill_q + ICW'(1);
				end
			end
			if (state_q == smt_pkg::S_DONE && state_d == smt_pkg::S_IDLE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			smt_pkg::S_IDLE: begin
				op_q        <= cmd.op;
				v_q         <= cmd.index[VW-1:0];
				pre_q       <= cmd.preimage[VW-1:0];
				given_q     <= cmd.given;
				scan_idx_q  <= '0;
				in_found_q  <= 1'b0;
				out_found_q <= 1'b0;
				in_at_q     <= '0;
				out_at_q    <= '0;
			end
			smt_pkg::S_SCAN: begin
				if (scan_issue) begin
					scan_idx_q <= scan_idx_q + SW'(1);
				end
			end
			smt_pkg::S_DECIDE: begin
				res_status_q <= d_status;
				res_member_q <= d_member;
				res_fpre_q   <= d_fpre;
				res_known_q  <= d_known;
				tgt_out_q    <= d_ins_out;
				ins_q        <= d_ins_in || d_ins_out;
				place_addr_q <= d_upd ? SW'(in_pos_q) : (d_ins_out ? SW'(out_at_q) : SW'(in_at_q));
				place_data_q <= {v_q, (d_given ? d_pre : {VW{1'b0}}), d_given};
				sh_q         <= d_ins_out ? (SW'(out_fill_q) - SW'(1)) : (SW'(in_fill_q) - SW'(1));
				sh_stop_q    <= d_ins_out ? SW'(out_at_q) : SW'(in_at_q);
			end
			smt_pkg::S_SHIFT: begin
				pend_addr_s1 <= sh_q + SW'(1);
				sh_q         <= sh_q - SW'(1);
			end
			smt_pkg::S_DONE: begin
				// load the result only once the previous one has left
				if (state_d == smt_pkg::S_IDLE) begin
					out_q.status         <= res_status_q;
					out_q.membership     <= res_member_q;
					out_q.found_preimage <= smt_pkg::FIELD_W'(res_fpre_q);
					out_q.preimage_known <= res_known_q;
					out_q.in_count       <= smt_pkg::COUNT_W'(in_fill_q);
					out_q.out_count      <= smt_pkg::COUNT_W'(out_fill_q);
					out_q.changed        <= changed_q;
				end
			end
			default: begin
				sh_q <= sh_q;
			end
		endcase
		// compare returning scan data against the item's index
		if (scan_vld_s1) begin
			if (scan_idx_s1 < SW'(in_fill_q)) begin
				if (in_rval == v_q && !in_found_q) begin
					in_found_q <= 1'b1;
					in_pos_q   <= scan_idx_s1[IAW-1:0];
					in_pre_q   <= in_rdata[VW:1];
					in_pv_q    <= in_rdata[0];
				end
				if (in_rval < v_q) begin
					in_at_q <= in_at_q + ICW'(1);
				end
			end
			if (scan_idx_s1 < SW'(out_fill_q)) begin
				if (out_rdata == v_q) begin
					out_found_q <= 1'b1;
				end
				if (out_rdata < v_q) begin
					out_at_q <= out_at_q + OCW'(1);
				end
			end
		end
		scan_idx_s1 <= scan_idx_q;
	end

`ifndef SYNTHESIS
	a_in_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_fill_q <= ICW'(IN_DEPTH))
		else $error("in-set fill count beyond depth");
	a_out_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_fill_q <= OCW'(OUT_DEPTH))
		else $error("out-set fill count beyond depth");
	a_insert_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smt_pkg::S_PLACE && ins_q && !tgt_out_q) |-> in_fill_q < ICW'(IN_DEPTH))
		else $error("insert into full in-set");
	a_sqdone_needs_square: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == smt_pkg::STAT_SQDONE) |-> sq_set_q)
		else $error("square reported done before it was set");
`endif

endmodule

### rtl/sorted_membership_table_core.sv
// Top level: sorted membership table with front decode, command queue and back engine.
// Each transaction scans both sets and then decides; an entry is shifted in when entries lie above
//   the insert point, and placed directly when it lands on top of the set or only gains a preimage.
// The back engine takes one transaction at a time; its rate is limited by the scan and shift
//   passes over each set RAM's single read port.
// The front stage and the two-entry queue keep accepting while the back engine works, until full.
// Reset (arst_n, asynchronous, active low) empties both sets at once by clearing fill counts.
`timescale 1ns / 1ps
module sorted_membership_table_core #(
	parameter int IN_DEPTH    = smt_pkg::IN_DEPTH_DEF,
	parameter int OUT_DEPTH   = smt_pkg::OUT_DEPTH_DEF,
	parameter int INDEX_WIDTH = smt_pkg::INDEX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  smt_pkg::smt_in_t            in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output smt_pkg::smt_out_t           out_data,
	input  logic                        cfg_we,
	input  logic [smt_pkg::FIELD_W-1:0] cfg_wdata
);

	localparam int CMD_W = $bits(smt_pkg::smt_cmd_t);

	// front to queue
	logic              fr_valid;
	logic              fr_ready;
	smt_pkg::smt_cmd_t fr_cmd;
	logic [CMD_W-1:0]  fr_bits;

	// queue to back
	logic              bk_valid;
	logic              bk_ready;
	logic [CMD_W-1:0]  bk_bits;
	smt_pkg::smt_cmd_t bk_cmd;

	assign fr_bits = fr_cmd;
	assign bk_cmd  = bk_bits;

	// Mask the fields to the index width and decode the action into an opcode.
	smt_front #(.INDEX_WIDTH(INDEX_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cmd_valid (fr_valid),
		.cmd_ready (fr_ready),
		.cmd       (fr_cmd)
	);

	// Hold decoded transactions so the front keeps taking input while the back is busy.
	smt_fifo #(.WIDTH(CMD_W)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  (fr_bits),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_data   (bk_bits)
	);

	// Scan both sets, decide the outcome, shift larger entries up and place the new one.
	// The result sits in an output register, so the next transaction starts while it waits.
	smt_back #(
		.IN_DEPTH    (IN_DEPTH),
		.OUT_DEPTH   (OUT_DEPTH),
		.INDEX_WIDTH (INDEX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (bk_valid),
		.cmd_ready (bk_ready),
		.cmd       (bk_cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
